// ===== rtl/epd_pkg.sv =====
`default_nettype none

package epd_pkg;

    localparam int DELTA_W = 16;
    localparam int POS_W   = 8;
    localparam int CFG_W   = 8;
    localparam int PROD_W  = 2 * CFG_W;

    localparam logic [POS_W-1:0]  BAND_HALF = 8'd5;
    localparam logic [CFG_W-1:0]  INT_DIV   = 8'd50;
    localparam logic [POS_W-1:0]  SAT_MAX   = 8'd255;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_COUNTS_PER_STEP = 2'd0;
    localparam t_cfg_idx CFG_PROP_GAIN       = 2'd1;
    localparam t_cfg_idx CFG_INT_GAIN        = 2'd2;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_unit_ctl;

endpackage

`default_nettype wire

// ===== rtl/encoder_position_pi_drive.sv =====
// Encoder position PI drive with a dead band around the target.
// Input channel: i_in_valid / o_in_stall carry one control tick (encoder_delta,
// target_position); a transfer happens when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall carry drive_level, direction_right
// and estimated_position, one result per tick.
// Configuration: i_cfg_we with i_cfg_index writes counts_per_step (0),
// prop_gain (1) or int_gain (2); other indexes are ignored. Write only while idle.
// The block takes no new tick until the previous one has been moved into the
// output register. The work is done by the bit-serial divider, run twice (16
// steps for counts_per_step, 16 steps for the divide by 50), and the 8-step
// shift-add multipliers in between.
// While a result waits in the output register under stall, the next tick is
// still taken and worked; it holds in its last step until the register frees.
// Reset: position estimate, tick counter and direction clear to zero (left);
// counts_per_step and prop_gain reset to 1, int_gain to 0; no result pending.
`default_nettype none

module encoder_position_pi_drive
    import epd_pkg::*;
(
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire signed [DELTA_W-1:0]    i_encoder_delta,
    input  wire [POS_W-1:0]             i_target_position,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic [POS_W-1:0]            o_drive_level,
    output logic                        o_direction_right,
    output logic [POS_W-1:0]            o_estimated_position,
    input  wire                         i_cfg_we,
    input  wire [1:0]                   i_cfg_index,
    input  wire [CFG_W-1:0]             i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_BAND = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_IDIV = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]         r_state;
    logic [2:0]         n_state;

    logic [CFG_W-1:0]   r_counts_per_step;
    logic [CFG_W-1:0]   r_prop_gain;
    logic [CFG_W-1:0]   r_int_gain;

    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_tick;
    logic               r_dir;

    logic [POS_W-1:0]   r_target;
    logic               r_neg;
    logic               r_zero;
    logic [PROD_W-1:0]  r_pprod;
    logic [POS_W-1:0]   r_drive;

    logic               r_out_valid;
    logic [POS_W-1:0]   r_out_drive;
    logic               r_out_dir;
    logic [POS_W-1:0]   r_out_pos;

    logic               w_in_xfer;
    logic               w_out_free;
    logic [DELTA_W-1:0] w_mag;

    logic               w_div_start;
    logic [DELTA_W-1:0] w_div_dividend;
    logic [CFG_W-1:0]   w_div_divisor;
    t_unit_ctl          w_div_ctl;
    logic [DELTA_W-1:0] w_div_quo;

    logic               w_mul_start;
    t_unit_ctl          w_pmul_ctl;
    t_unit_ctl          w_imul_ctl;
    logic [PROD_W-1:0]  w_pprod;
    logic [PROD_W-1:0]  w_iprod;

    logic [POS_W-1:0]   w_step;
    logic [POS_W:0]     w_pos_sum;
    logic [POS_W-1:0]   w_pos_next;

    logic               w_below;
    logic               w_above;
    logic [POS_W-1:0]   w_err;
    logic [POS_W-1:0]   w_tick_next;
    logic [PROD_W:0]    w_drive_sum;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_mag      = i_encoder_delta[DELTA_W-1] ? DELTA_W'(-i_encoder_delta)
                                                   : i_encoder_delta;

    // shared divider: encoder magnitude first, then the integral term by 50
    assign w_div_start    = w_in_xfer || ((r_state == S_MUL) && w_pmul_ctl.done);
    assign w_div_dividend = (r_state == S_IDLE) ? w_mag : w_iprod;
    assign w_div_divisor  = (r_state == S_IDLE) ? r_counts_per_step : INT_DIV;

    epd_sdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_ctl      (w_div_ctl),
        .o_quotient (w_div_quo)
    );

    assign w_step     = (w_div_quo[DELTA_W-1:POS_W] != '0) ? SAT_MAX
                                                           : w_div_quo[POS_W-1:0];
    assign w_pos_sum  = {1'b0, r_pos} + {1'b0, w_step};
    always_comb begin
        if (r_zero) begin
            w_pos_next = r_pos;
        end else if (r_neg) begin
            w_pos_next = w_pos_sum[POS_W] ? SAT_MAX : w_pos_sum[POS_W-1:0];
        end else begin
            w_pos_next = (r_pos > w_step) ? (r_pos - w_step) : '0;
        end
    end

    assign w_below = ({1'b0, r_pos} + {1'b0, BAND_HALF}) < {1'b0, r_target};
    assign w_above = {1'b0, r_pos} > ({1'b0, r_target} + {1'b0, BAND_HALF});
    always_comb begin
        if (w_below) begin
            w_err       = r_target - r_pos;
            w_tick_next = r_tick + POS_W'(1);
        end else if (w_above) begin
            w_err       = r_pos - r_target;
            w_tick_next = r_tick + POS_W'(1);
        end else begin
            w_err       = '0;
            w_tick_next = '0;
        end
    end

    assign w_mul_start = (r_state == S_BAND);

    epd_smul u_pmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mcand   (r_prop_gain),
        .i_mplier  (w_err),
        .o_ctl     (w_pmul_ctl),
        .o_product (w_pprod)
    );

    epd_smul u_imul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mul_start),
        .i_mcand   (r_int_gain),
        .i_mplier  (w_tick_next),
        .o_ctl     (w_imul_ctl),
        .o_product (w_iprod)
    );

    assign w_drive_sum = {1'b0, r_pprod} + {1'b0, w_div_quo};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_xfer) n_state = S_DIV;
            S_DIV:   if (w_div_ctl.done) n_state = S_BAND;
            S_BAND:  n_state = S_MUL;
            S_MUL:   if (w_pmul_ctl.done && w_imul_ctl.done) n_state = S_IDIV;
            S_IDIV:  if (w_div_ctl.done) n_state = S_OUT;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_counts_per_step <= 8'd1;
            r_prop_gain       <= 8'd1;
            r_int_gain        <= 8'd0;
            r_pos             <= '0;
            r_tick            <= '0;
            r_dir             <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_COUNTS_PER_STEP: r_counts_per_step <= i_cfg_data;
                    CFG_PROP_GAIN:       r_prop_gain       <= i_cfg_data;
                    CFG_INT_GAIN:        r_int_gain        <= i_cfg_data;
                    default:             ;
                endcase
            end
            if ((r_state == S_DIV) && w_div_ctl.done) begin
                r_pos <= w_pos_next;
            end
            if (r_state == S_BAND) begin
                r_tick <= w_tick_next;
                if (w_below) begin
                    r_dir <= 1'b1;
                end else if (w_above) begin
                    r_dir <= 1'b0;
                end
            end
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_target <= i_target_position;
            r_neg    <= i_encoder_delta[DELTA_W-1];
            r_zero   <= (i_encoder_delta == '0);
        end
        if ((r_state == S_MUL) && w_pmul_ctl.done) begin
            r_pprod <= w_pprod;
        end
        if ((r_state == S_IDIV) && w_div_ctl.done) begin
            r_drive <= (w_drive_sum[PROD_W:POS_W] != '0) ? SAT_MAX
                                                         : w_drive_sum[POS_W-1:0];
        end
        if ((r_state == S_OUT) && w_out_free) begin
            r_out_drive <= r_drive;
            r_out_dir   <= r_dir;
            r_out_pos   <= r_pos;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_drive_level        = r_out_drive;
    assign o_direction_right    = r_out_dir;
    assign o_estimated_position = r_out_pos;

endmodule

`default_nettype wire

// ===== rtl/epd_sdiv.sv =====
`default_nettype none

module epd_sdiv
    import epd_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire [DELTA_W-1:0]   i_dividend,
    input  wire [CFG_W-1:0]     i_divisor,
    output t_unit_ctl           o_ctl,
    output logic [DELTA_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(DELTA_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [CFG_W-1:0]   r_rem;
    logic [CFG_W-1:0]   r_divisor;
    logic [DELTA_W-1:0] r_quo;

    logic [CFG_W:0]     w_shift;
    logic [CFG_W:0]     w_diff;
    logic               w_ge;

    assign w_shift = {r_rem, r_quo[DELTA_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_divisor});
    assign w_diff  = w_shift - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt  <= r_cnt + CNT_W'(1);
                r_busy <= (r_cnt != CNT_W'(DELTA_W - 1));
                r_done <= (r_cnt == CNT_W'(DELTA_W - 1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[CFG_W-1:0] : w_shift[CFG_W-1:0];
            r_quo <= {r_quo[DELTA_W-2:0], w_ge};
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;
    assign o_quotient  = r_quo;

endmodule

`default_nettype wire

// ===== rtl/epd_smul.sv =====
`default_nettype none

module epd_smul
    import epd_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire [CFG_W-1:0]     i_mcand,
    input  wire [CFG_W-1:0]     i_mplier,
    output t_unit_ctl           o_ctl,
    output logic [PROD_W-1:0]   o_product
);

    localparam int CNT_W = $clog2(CFG_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [CFG_W-1:0]   r_mcand;
    logic [PROD_W-1:0]  r_prod;

    logic [CFG_W:0]     w_sum;

    assign w_sum = {1'b0, r_prod[PROD_W-1:CFG_W]}
                 + {1'b0, (r_prod[0] ? r_mcand : {CFG_W{1'b0}})};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt  <= r_cnt + CNT_W'(1);
                r_busy <= (r_cnt != CNT_W'(CFG_W - 1));
                r_done <= (r_cnt == CNT_W'(CFG_W - 1));
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_prod  <= {{CFG_W{1'b0}}, i_mplier};
        end else if (r_busy) begin
            r_prod <= {w_sum, r_prod[CFG_W-1:1]};
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_ctl.done  = r_done;
    assign o_product   = r_prod;

endmodule

`default_nettype wire
